// File: rtl/core/mhpq_pkg.sv
`timescale 1ns / 1ps

package mhpq_pkg;

    // Field widths of the request and result items
    localparam int KEY_W   = 32;
    localparam int PAY_W   = 64;
    localparam int COUNT_W = 10;

    // Request operations
    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_POP    = 1'b1
    } mhpq_op_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } mhpq_status_t;

    // One heap entry: key and the data word carried with it
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic signed [PAY_W-1:0] pay;
    } mhpq_entry_t;

    // Strobes from the sequencer to one level cell
    typedef struct packed {
        logic rd;
        logic wr;
        logic wr_hi;
    } mhpq_cell_req_t;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_POP_RD_LAST,
        S_POP_RD_ROOT,
        S_POP_LOAD,
        S_DN_RD,
        S_DN_CMP,
        S_EMIT
    } mhpq_state_t;

endpackage

// File: rtl/core/mhpq_in_if.sv
`timescale 1ns / 1ps

interface mhpq_in_if;
    logic                                valid;
    logic                                ready;
    logic                                opcode;
    logic signed [mhpq_pkg::KEY_W-1:0]   priority_req;
    logic signed [mhpq_pkg::PAY_W-1:0]   payload;

    modport source (output valid, opcode, priority_req, payload, input ready);
    modport sink   (input valid, opcode, priority_req, payload, output ready);
endinterface

// File: rtl/core/mhpq_out_if.sv
`timescale 1ns / 1ps

interface mhpq_out_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          status;
    logic signed [mhpq_pkg::KEY_W-1:0]   out_priority;
    logic signed [mhpq_pkg::PAY_W-1:0]   out_payload;
    logic [mhpq_pkg::COUNT_W-1:0]        count;

    modport source (output valid, status, out_priority, out_payload, count, input ready);
    modport sink   (input valid, status, out_priority, out_payload, count, output ready);
endinterface

// File: rtl/core/mhpq_cell.sv
`timescale 1ns / 1ps

// One heap level: sibling pairs stored as rows, left child in the low bank
// and right child in the high bank, so a parent sees both children in one read.
module mhpq_cell #(
    parameter int ROWS  = 1,
    parameter int ROW_W = 1
) (
    input  logic                        clk,
    input  mhpq_pkg::mhpq_cell_req_t    req,
    input  logic [ROW_W-1:0]            rd_row,
    input  logic [ROW_W-1:0]            wr_row,
    input  mhpq_pkg::mhpq_entry_t       wr_data,
    output mhpq_pkg::mhpq_entry_t       rd_lo,
    output mhpq_pkg::mhpq_entry_t       rd_hi
);

    mhpq_pkg::mhpq_entry_t lo_mem [ROWS];
    mhpq_pkg::mhpq_entry_t hi_mem [ROWS];
    mhpq_pkg::mhpq_entry_t rd_lo_reg;
    mhpq_pkg::mhpq_entry_t rd_hi_reg;

    // Write one side of a row
    always_ff @(posedge clk)
    begin
        if (req.wr && !req.wr_hi)
        begin
            lo_mem[wr_row] <= wr_data;
        end
        if (req.wr && req.wr_hi)
        begin
            hi_mem[wr_row] <= wr_data;
        end
    end

    // Read both sides of a row into the output register
    always_ff @(posedge clk)
    begin
        if (req.rd)
        begin
            rd_lo_reg <= lo_mem[rd_row];
            rd_hi_reg <= hi_mem[rd_row];
        end
    end

    assign rd_lo = rd_lo_reg;
    assign rd_hi = rd_hi_reg;

endmodule

// File: rtl/core/min_heap_priority_queue_core.sv
`timescale 1ns / 1ps

// Channel   Role   Handshake     Payload
// in_ch     sink   valid/ready   opcode, priority_req, payload
// out_ch    source valid/ready   status, out_priority, out_payload, count
//
// The heap is a chain of level cells, one memory per level; entries move one
// level per step between neighbouring cells through a single read/write bus.
// Each level step is a row read, then a compare and write.
// Empty pop and full insert go straight to the result; the next request is taken in idle.
// Reset clears the count and the control state; the level memories need none.
// A request is taken while the last result still waits in the output register;
// a stalled result holds the sequencer only in its final step.
module min_heap_priority_queue_core #(
    parameter int CAPACITY = 512
) (
    input  logic      clk,
    input  logic      rst_n,
    mhpq_in_if.sink   in_ch,
    mhpq_out_if.source out_ch
);

    localparam int LEVELS = $clog2(CAPACITY + 1);
    localparam int OW     = LEVELS - 1;
    localparam int LVW    = $clog2(LEVELS + 1);
    localparam int CW     = $clog2(CAPACITY + 1);

    // Mask of the offset bits valid at a level
    function automatic logic [OW-1:0] lvl_mask(input logic [LVW-1:0] lvl);
        lvl_mask = (OW'(1) << lvl) - OW'(1);
    endfunction

    mhpq_pkg::mhpq_state_t state_reg, state_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [LVW-1:0]        tail_lvl_reg, tail_lvl_next;
    logic [OW-1:0]         tail_off_reg, tail_off_next;
    logic                  out_valid_reg, out_valid_next;

    logic [LVW-1:0]        pos_lvl_reg, pos_lvl_next;
    logic [OW-1:0]         pos_off_reg, pos_off_next;
    mhpq_pkg::mhpq_entry_t mv_reg, mv_next;
    logic [1:0]            res_status_reg, res_status_next;
    mhpq_pkg::mhpq_entry_t res_reg, res_next;
    logic [1:0]            out_status_reg, out_status_next;
    mhpq_pkg::mhpq_entry_t out_res_reg, out_res_next;
    logic [mhpq_pkg::COUNT_W-1:0] out_count_reg, out_count_next;
    logic [LVW-1:0]        rd_lvl_q_reg;

    logic                  rd_en;
    logic [LVW-1:0]        rd_lvl;
    logic [OW-1:0]         rd_row;
    logic                  wr_en;
    logic [LVW-1:0]        wr_lvl;
    logic [OW-1:0]         wr_off;
    logic [OW-1:0]         wr_row;
    mhpq_pkg::mhpq_entry_t wr_data;

    mhpq_pkg::mhpq_entry_t cell_lo [LEVELS];
    mhpq_pkg::mhpq_entry_t cell_hi [LEVELS];
    mhpq_pkg::mhpq_entry_t sel_lo;
    mhpq_pkg::mhpq_entry_t sel_hi;

    logic [LVW-1:0]        tail_inc_lvl, tail_dec_lvl;
    logic [OW-1:0]         tail_inc_off, tail_dec_off;
    logic [LVW-1:0]        child_lvl;
    logic [OW:0]           child_left, child_right, tail_off_ext;
    logic                  left_ok, right_ok;
    logic [OW-1:0]         par_off;
    mhpq_pkg::mhpq_entry_t par_e, pick_e;
    logic                  pick_hi;
    logic                  in_acc;
    logic [31:0]           count_wide;

    assign in_acc     = in_ch.valid && in_ch.ready;
    assign count_wide = 32'(count_reg);

    // Level cells
    assign wr_row = wr_off >> 1;

    for (genvar g = 0; g < LEVELS; g++)
    begin : g_lvl
        localparam int BASE    = (2 ** g) - 1;
        localparam int ENTRIES = ((CAPACITY - BASE) < (2 ** g)) ? (CAPACITY - BASE) : (2 ** g);
        localparam int ROWS    = (ENTRIES + 1) / 2;
        localparam int ROW_W   = (ROWS > 1) ? $clog2(ROWS) : 1;

        mhpq_pkg::mhpq_cell_req_t req;

        assign req.rd    = rd_en && (rd_lvl == LVW'(g));
        assign req.wr    = wr_en && (wr_lvl == LVW'(g));
        assign req.wr_hi = wr_off[0];

        mhpq_cell #(
            .ROWS  (ROWS),
            .ROW_W (ROW_W)
        ) u_cell (
            .clk     (clk),
            .req     (req),
            .rd_row  (rd_row[ROW_W-1:0]),
            .wr_row  (wr_row[ROW_W-1:0]),
            .wr_data (wr_data),
            .rd_lo   (cell_lo[g]),
            .rd_hi   (cell_hi[g])
        );
    end

    // Pick the row returned by the level read last cycle
    always_comb
    begin
        sel_lo = cell_lo[0];
        sel_hi = cell_hi[0];
        for (int l = 0; l < LEVELS; l++)
        begin
            if (rd_lvl_q_reg == LVW'(l))
            begin
                sel_lo = cell_lo[l];
                sel_hi = cell_hi[l];
            end
        end
    end

    // Tail position (next free slot) stepped forward and back
    always_comb
    begin
        if (tail_off_reg == lvl_mask(tail_lvl_reg))
        begin
            tail_inc_lvl = tail_lvl_reg + LVW'(1);
            tail_inc_off = '0;
        end
        else
        begin
            tail_inc_lvl = tail_lvl_reg;
            tail_inc_off = tail_off_reg + OW'(1);
        end
        if (tail_off_reg == '0)
        begin
            tail_dec_lvl = tail_lvl_reg - LVW'(1);
            tail_dec_off = lvl_mask(tail_lvl_reg - LVW'(1));
        end
        else
        begin
            tail_dec_lvl = tail_lvl_reg;
            tail_dec_off = tail_off_reg - OW'(1);
        end
    end

    // Children of the current position that lie below the count
    assign child_lvl    = pos_lvl_reg + LVW'(1);
    assign child_left   = {pos_off_reg, 1'b0};
    assign child_right  = {pos_off_reg, 1'b1};
    assign tail_off_ext = {1'b0, tail_off_reg};
    assign left_ok  = (child_lvl < tail_lvl_reg) ||
                      ((child_lvl == tail_lvl_reg) && (child_left < tail_off_ext));
    assign right_ok = (child_lvl < tail_lvl_reg) ||
                      ((child_lvl == tail_lvl_reg) && (child_right < tail_off_ext));

    // Parent entry for sift up, chosen child for sift down
    assign par_off = pos_off_reg >> 1;
    assign par_e   = par_off[0] ? sel_hi : sel_lo;
    assign pick_hi = right_ok && ($signed(sel_hi.key) < $signed(sel_lo.key));
    assign pick_e  = pick_hi ? sel_hi : sel_lo;

    // Sequencer: next state, bus strobes and result
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        tail_lvl_next   = tail_lvl_reg;
        tail_off_next   = tail_off_reg;
        out_valid_next  = out_valid_reg;
        pos_lvl_next    = pos_lvl_reg;
        pos_off_next    = pos_off_reg;
        mv_next         = mv_reg;
        res_status_next = res_status_reg;
        res_next        = res_reg;
        out_status_next = out_status_reg;
        out_res_next    = out_res_reg;
        out_count_next  = out_count_reg;
        in_ch.ready     = 1'b0;
        rd_en           = 1'b0;
        rd_lvl          = '0;
        rd_row          = '0;
        wr_en           = 1'b0;
        wr_lvl          = pos_lvl_reg;
        wr_off          = pos_off_reg;
        wr_data         = mv_reg;

        // Drop the result once taken
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            mhpq_pkg::S_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    res_next        = '0;
                    res_status_next = mhpq_pkg::STAT_OK;
                    state_next      = mhpq_pkg::S_EMIT;
                    if (in_ch.opcode == mhpq_pkg::OP_INSERT)
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            res_status_next = mhpq_pkg::STAT_FULL;
                        end
                        else
                        begin
                            mv_next.key   = in_ch.priority_req;
                            mv_next.pay   = in_ch.payload;
                            pos_lvl_next  = tail_lvl_reg;
                            pos_off_next  = tail_off_reg;
                            tail_lvl_next = tail_inc_lvl;
                            tail_off_next = tail_inc_off;
                            count_next    = count_reg + CW'(1);
                            state_next    = mhpq_pkg::S_UP_RD;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = mhpq_pkg::STAT_EMPTY;
                        end
                        else
                        begin
                            tail_lvl_next = tail_dec_lvl;
                            tail_off_next = tail_dec_off;
                            count_next    = count_reg - CW'(1);
                            state_next    = mhpq_pkg::S_POP_RD_LAST;
                        end
                    end
                end
            end

            mhpq_pkg::S_UP_RD:
            begin
                if (pos_lvl_reg == '0)
                begin
                    wr_en      = 1'b1;
                    state_next = mhpq_pkg::S_EMIT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_lvl     = pos_lvl_reg - LVW'(1);
                    rd_row     = par_off >> 1;
                    state_next = mhpq_pkg::S_UP_CMP;
                end
            end

            mhpq_pkg::S_UP_CMP:
            begin
                wr_en = 1'b1;
                if ($signed(mv_reg.key) < $signed(par_e.key))
                begin
                    // Move the parent down one level and climb
                    wr_data      = par_e;
                    pos_lvl_next = pos_lvl_reg - LVW'(1);
                    pos_off_next = par_off;
                    state_next   = mhpq_pkg::S_UP_RD;
                end
                else
                begin
                    state_next = mhpq_pkg::S_EMIT;
                end
            end

            mhpq_pkg::S_POP_RD_LAST:
            begin
                rd_en      = 1'b1;
                rd_lvl     = tail_lvl_reg;
                rd_row     = tail_off_reg >> 1;
                state_next = mhpq_pkg::S_POP_RD_ROOT;
            end

            mhpq_pkg::S_POP_RD_ROOT:
            begin
                mv_next    = tail_off_reg[0] ? sel_hi : sel_lo;
                rd_en      = 1'b1;
                rd_lvl     = '0;
                rd_row     = '0;
                state_next = mhpq_pkg::S_POP_LOAD;
            end

            mhpq_pkg::S_POP_LOAD:
            begin
                res_next     = sel_lo;
                pos_lvl_next = '0;
                pos_off_next = '0;
                state_next   = mhpq_pkg::S_DN_RD;
            end

            mhpq_pkg::S_DN_RD:
            begin
                if (left_ok)
                begin
                    rd_en      = 1'b1;
                    rd_lvl     = child_lvl;
                    rd_row     = pos_off_reg;
                    state_next = mhpq_pkg::S_DN_CMP;
                end
                else
                begin
                    wr_en      = 1'b1;
                    state_next = mhpq_pkg::S_EMIT;
                end
            end

            mhpq_pkg::S_DN_CMP:
            begin
                wr_en = 1'b1;
                if ($signed(pick_e.key) < $signed(mv_reg.key))
                begin
                    // Move the smaller child up one level and descend
                    wr_data      = pick_e;
                    pos_lvl_next = child_lvl;
                    pos_off_next = child_left[OW-1:0] | OW'(pick_hi);
                    state_next   = mhpq_pkg::S_DN_RD;
                end
                else
                begin
                    state_next = mhpq_pkg::S_EMIT;
                end
            end

            mhpq_pkg::S_EMIT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_res_next    = res_reg;
                    out_count_next  = count_wide[mhpq_pkg::COUNT_W-1:0];
                    state_next      = mhpq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = mhpq_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mhpq_pkg::S_IDLE;
            count_reg     <= '0;
            tail_lvl_reg  <= '0;
            tail_off_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            tail_lvl_reg  <= tail_lvl_next;
            tail_off_reg  <= tail_off_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        pos_lvl_reg    <= pos_lvl_next;
        pos_off_reg    <= pos_off_next;
        mv_reg         <= mv_next;
        res_status_reg <= res_status_next;
        res_reg        <= res_next;
        out_status_reg <= out_status_next;
        out_res_reg    <= out_res_next;
        out_count_reg  <= out_count_next;
        if (rd_en)
        begin
            rd_lvl_q_reg <= rd_lvl;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.status       = out_status_reg;
    assign out_ch.out_priority = out_res_reg.key;
    assign out_ch.out_payload  = out_res_reg.pay;
    assign out_ch.count        = out_count_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_tail_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> ((tail_lvl_reg == '0) && (tail_off_reg == '0)))
        else $error("tail position out of step with count");

    a_bus_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && wr_en && (rd_lvl == wr_lvl)))
        else $error("read and write on one level cell together");

    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (in_ch.opcode == mhpq_pkg::OP_INSERT) && (count_reg == CW'(CAPACITY)))
        |=> (count_reg == $past(count_reg)))
        else $error("insert into full heap changed the count");

    a_dn_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mhpq_pkg::S_DN_CMP) |-> (child_lvl < LVW'(LEVELS)))
        else $error("sift down past the last level");

endmodule
